[hw/rtl/stl_pkg.sv]
// Package for the source token lexer: payload structs, token codes, keyword helper.
// Used by every module of the lexer; depends on nothing.
package stl_pkg;

  localparam int LINE_W_DEF = 16;
  localparam int COL_W_DEF = 12;
  localparam int LEN_W = 12;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  localparam logic [5:0] TK_GT = 6'd7;
  localparam logic [5:0] TK_NOT = 6'd11;
  localparam logic [5:0] TK_ID = 6'd30;
  localparam logic [5:0] TK_STRING = 6'd31;
  localparam logic [5:0] TK_INT = 6'd32;
  localparam logic [5:0] TK_FLOAT = 6'd33;
  localparam logic [5:0] TK_EOS = 6'd34;
  localparam logic [5:0] TK_ERROR = 6'd35;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_BAD_CHAR = 2'd1;
  localparam logic [1:0] ERR_SECOND_POINT = 2'd2;
  localparam logic [1:0] ERR_BROKEN_STRING = 2'd3;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [1:0]  error_kind;
    logic [15:0] token_line;
    logic [11:0] token_column;
    logic [11:0] token_length;
    logic        last_result;
  } out_item_t;

  // One queue entry: up to two tokens produced by one input.
  typedef struct packed {
    logic      two;
    out_item_t first;
    out_item_t second;
  } tok_pair_t;

  function automatic logic [5:0] keyword_kind(input logic [55:0] p, input logic [LEN_W-1:0] n);
    logic [5:0] k;
    k = TK_ID;
    case (n)
      12'd2: begin
        if (p[15:0] == "ro") k = 6'd16;
        if (p[15:0] == "od") k = 6'd21;
        if (p[15:0] == "fi") k = 6'd28;
      end
      12'd3: begin
        if (p[23:0] == "dna") k = 6'd15;
        if (p[23:0] == "dne") k = 6'd23;
        if (p[23:0] == "ton") k = TK_NOT;
      end
      12'd4: begin
        if (p[31:0] == "neht") k = 6'd22;
        if (p[31:0] == "eurt") k = 6'd26;
        if (p[31:0] == "esle") k = 6'd29;
      end
      12'd5: begin
        if (p[39:0] == "daeri") k = 6'd17;
        if (p[39:0] == "daers") k = 6'd18;
        if (p[39:0] == "daerf") k = 6'd19;
        if (p[39:0] == "elihw") k = 6'd20;
        if (p[39:0] == "tnirp") k = 6'd24;
        if (p[39:0] == "eslaf") k = 6'd27;
      end
      12'd7: begin
        if (p == "nltnirp") k = 6'd25;
      end
      default: k = TK_ID;
    endcase
    return k;
  endfunction

endpackage

[hw/rtl/stl_front.sv]
// Front of the lexer: accepts characters, keeps scan state and counters, forms token pairs.
// Depends on stl_pkg.
module stl_front #(
  parameter int LINE_WIDTH = stl_pkg::LINE_W_DEF,
  parameter int COLUMN_WIDTH = stl_pkg::COL_W_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  stl_pkg::in_item_t  in_data,
  output logic               in_ready,
  output logic               push,
  output stl_pkg::tok_pair_t push_data,
  input  logic               q_full
);
  import stl_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE, M_COMMENT, M_COMPARE, M_WORD, M_NUMBER, M_STRING
  } mode_t;

  mode_t scan_mode, scan_mode_next;
  logic [LINE_WIDTH-1:0] line_count, line_count_next, start_line, start_line_next;
  logic [COLUMN_WIDTH-1:0] column_count, column_count_next, start_column, start_column_next;
  logic [LEN_W-1:0] lexeme_length, lexeme_length_next;
  logic [55:0] word_prefix, word_prefix_next;
  logic [1:0] pending_compare_char, pending_compare_char_next;
  logic seen_decimal, seen_decimal_next;

  logic [7:0] c;
  logic is_alpha, is_digit, is_space, rescan, fire;
  logic [LEN_W-1:0] len_inc;
  out_item_t tok [2];
  logic [1:0] n;

  assign in_ready = !q_full;
  assign fire = in_valid && in_ready;
  assign c = in_data.char_code;
  assign is_alpha = (c inside {[8'h61:8'h7A], [8'h41:8'h5A]});
  assign is_digit = (c inside {[8'h30:8'h39]});
  assign is_space = (c == 8'h20) || (c inside {[8'd9:8'd13]});
  assign len_inc = (lexeme_length < LEN_MAX) ? lexeme_length + 1'b1 : LEN_MAX;

  function automatic out_item_t mk(input logic [5:0] k, input logic [1:0] e,
                                   input logic [LINE_WIDTH-1:0] l,
                                   input logic [COLUMN_WIDTH-1:0] col,
                                   input logic [LEN_W-1:0] len);
    out_item_t o;
    o.token_kind = k;
    o.error_kind = e;
    o.token_line = 16'(l);
    o.token_column = 12'(col);
    o.token_length = len;
    o.last_result = 1'b0;
    return o;
  endfunction

  always_comb begin
    logic [5:0] pk;
    logic [1:0] pe;
    logic       pv;
    scan_mode_next = scan_mode;
    line_count_next = line_count;
    column_count_next = column_count;
    start_line_next = start_line;
    start_column_next = start_column;
    lexeme_length_next = lexeme_length;
    word_prefix_next = word_prefix;
    pending_compare_char_next = pending_compare_char;
    seen_decimal_next = seen_decimal;
    tok[0] = '0;
    tok[1] = '0;
    n = 2'd0;
    rescan = 1'b1;
    pv = 1'b1;
    pk = TK_ID;
    pe = ERR_NONE;
    case (scan_mode)
      M_COMPARE: pk = TK_GT + {3'd0, pending_compare_char, 1'b0};
      M_WORD: pk = (lexeme_length > 12'd7) ? TK_ID : keyword_kind(word_prefix, lexeme_length);
      M_NUMBER: pk = seen_decimal ? TK_FLOAT : TK_INT;
      M_STRING: begin
        pk = TK_ERROR;
        pe = ERR_BROKEN_STRING;
      end
      default: pv = 1'b0;
    endcase
    if (in_data.end_of_input) begin
      if (pv) begin
        tok[0] = mk(pk, pe, start_line, start_column,
                    (scan_mode == M_COMPARE) ? LEN_W'(1) : lexeme_length);
        n = 2'd1;
      end
      tok[n[0]] = mk(TK_EOS, ERR_NONE, line_count,
                     (column_count != '1) ? column_count + 1'b1 : column_count, '0);
      n = n + 2'd1;
      scan_mode_next = M_IDLE;
      line_count_next = '0;
      column_count_next = '0;
      start_line_next = '0;
      start_column_next = '0;
      lexeme_length_next = '0;
      word_prefix_next = '0;
      pending_compare_char_next = '0;
      seen_decimal_next = 1'b0;
    end else begin
      if (c == 8'h0A) begin
        if (line_count != '1) line_count_next = line_count + 1'b1;
        column_count_next = '0;
      end else if (column_count != '1) begin
        column_count_next = column_count + 1'b1;
      end
      case (scan_mode)
        M_COMMENT: begin
          if (c == 8'h0A) scan_mode_next = M_IDLE;
          rescan = 1'b0;
        end
        M_COMPARE: begin
          if (c == "=") begin
            tok[0] = mk(pk + 6'd1, ERR_NONE, start_line, start_column, LEN_W'(2));
            n = 2'd1;
            scan_mode_next = M_IDLE;
            rescan = 1'b0;
          end else begin
            tok[0] = mk(pk, ERR_NONE, start_line, start_column, LEN_W'(1));
            n = 2'd1;
            scan_mode_next = M_IDLE;
          end
        end
        M_WORD: begin
          if (is_alpha || is_digit) begin
            if (lexeme_length < 12'd7)
              word_prefix_next = word_prefix | (56'(c) << {lexeme_length[2:0], 3'b000});
            lexeme_length_next = len_inc;
            rescan = 1'b0;
          end else begin
            tok[0] = mk(pk, ERR_NONE, start_line, start_column, lexeme_length);
            n = 2'd1;
            scan_mode_next = M_IDLE;
          end
        end
        M_NUMBER: begin
          if (is_digit) begin
            lexeme_length_next = len_inc;
            rescan = 1'b0;
          end else if (c == ".") begin
            lexeme_length_next = len_inc;
            if (seen_decimal) begin
              tok[0] = mk(TK_ERROR, ERR_SECOND_POINT, start_line, start_column, len_inc);
              n = 2'd1;
              scan_mode_next = M_IDLE;
            end
            seen_decimal_next = 1'b1;
            rescan = 1'b0;
          end else begin
            tok[0] = mk(pk, ERR_NONE, start_line, start_column, lexeme_length);
            n = 2'd1;
            scan_mode_next = M_IDLE;
          end
        end
        M_STRING: begin
          if (c == 8'h22) begin
            tok[0] = mk(TK_STRING, ERR_NONE, start_line, start_column, lexeme_length);
            n = 2'd1;
            scan_mode_next = M_IDLE;
          end else if (c == 8'h0A) begin
            tok[0] = mk(TK_ERROR, ERR_BROKEN_STRING, start_line, start_column, lexeme_length);
            n = 2'd1;
            scan_mode_next = M_IDLE;
          end else begin
            lexeme_length_next = len_inc;
          end
          rescan = 1'b0;
        end
        default: scan_mode_next = M_IDLE;
      endcase
      if (rescan && !is_space) begin
        start_line_next = line_count_next;
        start_column_next = column_count_next;
        case (c)
          "#": scan_mode_next = M_COMMENT;
          ";", "+", "-", "*", "/", "(", ")": begin
            case (c)
              ";": pk = 6'd0;
              "+": pk = 6'd1;
              "-": pk = 6'd2;
              "*": pk = 6'd3;
              "/": pk = 6'd4;
              "(": pk = 6'd5;
              default: pk = 6'd6;
            endcase
            tok[n[0]] = mk(pk, ERR_NONE, line_count_next, column_count_next, LEN_W'(1));
            n = n + 2'd1;
          end
          ">", "=", "!", "<": begin
            scan_mode_next = M_COMPARE;
            case (c)
              ">": pending_compare_char_next = 2'd0;
              "=": pending_compare_char_next = 2'd1;
              "!": pending_compare_char_next = 2'd2;
              default: pending_compare_char_next = 2'd3;
            endcase
          end
          8'h22: begin
            scan_mode_next = M_STRING;
            lexeme_length_next = '0;
          end
          default: begin
            if (is_alpha) begin
              scan_mode_next = M_WORD;
              lexeme_length_next = LEN_W'(1);
              word_prefix_next = 56'(c);
            end else if (is_digit) begin
              scan_mode_next = M_NUMBER;
              lexeme_length_next = LEN_W'(1);
              seen_decimal_next = 1'b0;
            end else begin
              tok[n[0]] = mk(TK_ERROR, ERR_BAD_CHAR, line_count_next, column_count_next,
                             LEN_W'(1));
              n = n + 2'd1;
            end
          end
        endcase
      end
    end
    if (n == 2'd1) tok[0].last_result = 1'b1;
    if (n == 2'd2) tok[1].last_result = 1'b1;
  end

  assign push = fire && (n != 2'd0);
  assign push_data = '{two: n[1], first: tok[0], second: tok[1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode <= M_IDLE;
      line_count <= '0;
      column_count <= '0;
      start_line <= '0;
      start_column <= '0;
      lexeme_length <= '0;
      word_prefix <= '0;
      pending_compare_char <= '0;
      seen_decimal <= 1'b0;
    end else if (fire) begin
      scan_mode <= scan_mode_next;
      line_count <= line_count_next;
      column_count <= column_count_next;
      start_line <= start_line_next;
      start_column <= start_column_next;
      lexeme_length <= lexeme_length_next;
      word_prefix <= word_prefix_next;
      pending_compare_char <= pending_compare_char_next;
      seen_decimal <= seen_decimal_next;
    end
  end
endmodule

[hw/rtl/stl_queue.sv]
// Short queue of token pairs between the lexer front and the output stage.
// Depends on stl_pkg.
module stl_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  stl_pkg::tok_pair_t push_data,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output stl_pkg::tok_pair_t head
);
  import stl_pkg::*;

  tok_pair_t slots [2];
  logic wp, rp;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head = slots[rp];

  always_ff @(posedge clk) begin
    if (push) slots[wp] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= !wp;
      if (pop) rp <= !rp;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

[hw/rtl/stl_back.sv]
// Output stage of the lexer: sends the one or two tokens of each queue entry in order.
// Depends on stl_pkg.
module stl_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  stl_pkg::tok_pair_t q_head,
  output logic               q_pop,
  output logic               out_valid,
  output stl_pkg::out_item_t out_data,
  input  logic               out_ready
);
  import stl_pkg::*;

  logic sel;

  assign out_valid = q_valid;
  assign out_data = sel ? q_head.second : q_head.first;
  assign q_pop = q_valid && out_ready && (sel || !q_head.two);

  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= 1'b0;
    end else if (q_valid && out_ready) begin
      sel <= !sel && q_head.two;
    end
  end
endmodule

[hw/rtl/source_token_lexer_top.sv]
// Top level of the source token lexer: front, token queue and output stage.
// Depends on stl_pkg, stl_front, stl_queue and stl_back.
//
// Usage: the in channel takes one request per cycle while in_ready is high,
// either a source byte or an end-of-input mark. Each request yields zero, one
// or two tokens on the out channel; last_result marks the final token of a
// request. The front updates the scan state in the cycle a request is taken,
// and its tokens enter a two-entry queue, so a token can be taken in the cycle
// after its request. Throughput is one request per cycle while the queue has
// room; a request giving two tokens holds its queue entry until both are
// sent. When the receiver stalls, the queue fills and in_ready falls once both
// entries are occupied; nothing is lost. Reset clears the scan state, the
// counters and the queue; end of input returns all scan state to reset.
module source_token_lexer_top #(
  parameter int LINE_WIDTH = stl_pkg::LINE_W_DEF,
  parameter int COLUMN_WIDTH = stl_pkg::COL_W_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  stl_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output stl_pkg::out_item_t out_data
);
  import stl_pkg::*;

  logic push, full, pop, not_empty;
  tok_pair_t push_data, head;

  stl_front #(.LINE_WIDTH(LINE_WIDTH), .COLUMN_WIDTH(COLUMN_WIDTH)) u_front (
    .clk, .rst, .in_valid, .in_data, .in_ready,
    .push, .push_data, .q_full(full)
  );

  stl_queue u_queue (
    .clk, .rst, .push, .push_data, .full, .pop, .not_empty, .head
  );

  stl_back u_back (
    .clk, .rst, .q_valid(not_empty), .q_head(head), .q_pop(pop),
    .out_valid, .out_data, .out_ready
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("token pushed into a full queue");
  a_eos_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.token_kind == TK_EOS) |-> out_data.last_result)
    else $error("end of stream not marked last");
  a_err_kind: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.token_kind != TK_ERROR) |-> out_data.error_kind == ERR_NONE)
    else $error("error code on a token that is not an error");
endmodule
